@@ design/rpf_pkg.sv @@
// rpf_pkg: shared constants and types for the resonance pair finder
// depends on nothing
`default_nettype none
package rpf_pkg;
    localparam int MaxParticles  = 256;
    localparam int MaxCandidates = 63;
    localparam logic [63:0] DistSqLimit = 64'd281474976;
    localparam int IdxW = $clog2(MaxParticles);
    localparam int CntW = IdxW + 1;
    localparam int CandW = 6;

    localparam logic [2:0] REG_MASS   = 3'd0;
    localparam logic [2:0] REG_WINDOW = 3'd1;
    localparam logic [2:0] REG_FSA    = 3'd2;
    localparam logic [2:0] REG_FSB    = 3'd3;
    localparam logic [2:0] REG_SSA    = 3'd4;
    localparam logic [2:0] REG_SSB    = 3'd5;
    localparam logic [2:0] REG_CH2ON  = 3'd6;
    localparam logic [2:0] REG_CHECK  = 3'd7;

    // controller to datapath commands
    typedef struct packed {
        logic           load;      // input beat accepted
        logic           rd;        // read pair (a,b) from lists
        logic           chan;      // channel of pair being read
        logic [IdxW-1:0] a_idx;
        logic [IdxW-1:0] b_idx;
        logic           clear;     // end of event reset of counts
    } rpf_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [CntW-1:0] cnt0;
        logic [CntW-1:0] cnt1;
        logic [CntW-1:0] cnt2;
        logic [CntW-1:0] cnt3;
        logic            drop;
        logic            ch2on;
    } rpf_stat_t;
endpackage
`default_nettype wire

@@ design/rpf_datapath.sv @@
// rpf_datapath: particle stores, index lists and the pair test pipeline
// depends on rpf_pkg
`default_nettype none
module rpf_datapath
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic [23:0] species_code,
    input  wire logic [31:0] energy,
    input  wire logic [31:0] mom_x,
    input  wire logic [31:0] mom_y,
    input  wire logic [31:0] mom_z,
    input  wire logic [31:0] pos_t,
    input  wire logic [31:0] pos_x,
    input  wire logic [31:0] pos_y,
    input  wire logic [31:0] pos_z,
    input  rpf_pkg::rpf_cmd_t cmd,
    output rpf_pkg::rpf_stat_t stat,
    output logic pass,          // pair result valid, registered at the end of the rd tag pipe
    output logic pass_chan,
    output logic [32:0] p_e,
    output logic [32:0] p_x,
    output logic [32:0] p_y,
    output logic [32:0] p_z,
    output logic [31:0] v_t,
    output logic [31:0] v_x,
    output logic [31:0] v_y,
    output logic [31:0] v_z
);
    import rpf_pkg::*;

    logic [23:0] mass_reg, window_reg, fsa_reg, fsb_reg, ssa_reg, ssb_reg;
    logic ch2on_reg, check_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_reg   <= 24'd1068498;
            window_reg <= 24'd105;
            fsa_reg    <= 24'd321;
            fsb_reg    <= 24'hFFFEBF;
            ssa_reg    <= 24'd311;
            ssb_reg    <= 24'hFFFEC9;
            ch2on_reg  <= 1'b1;
            check_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MASS:   mass_reg   <= cfg_data;
                REG_WINDOW: window_reg <= cfg_data;
                REG_FSA:    fsa_reg    <= cfg_data;
                REG_FSB:    fsb_reg    <= cfg_data;
                REG_SSA:    ssa_reg    <= cfg_data;
                REG_SSB:    ssb_reg    <= cfg_data;
                REG_CH2ON:  ch2on_reg  <= cfg_data[0];
                REG_CHECK:  check_reg  <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // species match and store write
    logic [3:0] hit;
    logic [CntW-1:0] stored_reg, stored_next;
    logic [CntW-1:0] cnt_reg [4];
    logic drop_reg;
    logic do_store;

    assign hit[0] = species_code == fsa_reg;
    assign hit[1] = species_code == fsb_reg;
    assign hit[2] = ch2on_reg && species_code == ssa_reg;
    assign hit[3] = ch2on_reg && species_code == ssb_reg;
    assign do_store = cmd.load && check_reg && (|hit)
                      && stored_reg < CntW'(MaxParticles);
    assign stored_next = stored_reg + CntW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg <= '0;
            drop_reg   <= 1'b0;
            for (int k = 0; k < 4; k++)
                cnt_reg[k] <= '0;
        end
        else if (cmd.clear)
        begin
            stored_reg <= '0;
            drop_reg   <= 1'b0;
            for (int k = 0; k < 4; k++)
                cnt_reg[k] <= '0;
        end
        else if (cmd.load && check_reg && (|hit))
        begin
            if (do_store)
            begin
                stored_reg <= stored_next;
                for (int k = 0; k < 4; k++)
                    if (hit[k])
                        cnt_reg[k] <= cnt_reg[k] + CntW'(1);
            end
            else
                drop_reg <= 1'b1;
        end
    end

    assign stat.cnt0  = cnt_reg[0];
    assign stat.cnt1  = cnt_reg[1];
    assign stat.cnt2  = cnt_reg[2];
    assign stat.cnt3  = cnt_reg[3];
    assign stat.drop  = drop_reg;
    assign stat.ch2on = ch2on_reg;

    // index lists: one memory per list
    logic [IdxW-1:0] list0 [MaxParticles];
    logic [IdxW-1:0] list1 [MaxParticles];
    logic [IdxW-1:0] list2 [MaxParticles];
    logic [IdxW-1:0] list3 [MaxParticles];
    logic [IdxW-1:0] ia_reg, ib_reg;
    logic rd1_reg, ch1_reg;

    always_ff @(posedge clk)
    begin
        if (do_store && hit[0]) list0[cnt_reg[0][IdxW-1:0]] <= stored_reg[IdxW-1:0];
        if (do_store && hit[1]) list1[cnt_reg[1][IdxW-1:0]] <= stored_reg[IdxW-1:0];
        if (do_store && hit[2]) list2[cnt_reg[2][IdxW-1:0]] <= stored_reg[IdxW-1:0];
        if (do_store && hit[3]) list3[cnt_reg[3][IdxW-1:0]] <= stored_reg[IdxW-1:0];
        ia_reg <= cmd.chan ? list2[cmd.a_idx] : list0[cmd.a_idx];
        ib_reg <= cmd.chan ? list3[cmd.b_idx] : list1[cmd.b_idx];
    end

    // particle stores: 256-bit wide rows, two read ports
    logic [255:0] store_mem [MaxParticles];
    logic [255:0] ra_reg, rb_reg;
    logic rd2_reg, ch2_reg;

    always_ff @(posedge clk)
    begin
        if (do_store)
            store_mem[stored_reg[IdxW-1:0]] <=
                {energy, mom_x, mom_y, mom_z, pos_t, pos_x, pos_y, pos_z};
        ra_reg <= store_mem[ia_reg];
        rb_reg <= store_mem[ib_reg];
    end

    // stage 3: sums, differences, window bounds
    logic signed [32:0] se_reg, sx_reg, sy_reg, sz_reg;
    logic signed [32:0] dt_reg, dx_reg, dy_reg, dz_reg;
    logic [31:0] vt_reg, vx_reg, vy_reg, vz_reg;
    logic [23:0] lo_reg;
    logic [24:0] hi_reg;
    logic lo_ge_reg;
    logic rd3_reg, ch3_reg;

    function automatic logic signed [32:0] sx(input logic [31:0] v);
        sx = {v[31], v};
    endfunction

    always_ff @(posedge clk)
    begin
        se_reg <= sx(ra_reg[255:224]) + sx(rb_reg[255:224]);
        sx_reg <= sx(ra_reg[223:192]) + sx(rb_reg[223:192]);
        sy_reg <= sx(ra_reg[191:160]) + sx(rb_reg[191:160]);
        sz_reg <= sx(ra_reg[159:128]) + sx(rb_reg[159:128]);
        dt_reg <= sx(ra_reg[127:96]) - sx(rb_reg[127:96]);
        dx_reg <= sx(ra_reg[95:64])  - sx(rb_reg[95:64]);
        dy_reg <= sx(ra_reg[63:32])  - sx(rb_reg[63:32]);
        dz_reg <= sx(ra_reg[31:0])   - sx(rb_reg[31:0]);
        vt_reg <= ra_reg[127:96];
        vx_reg <= ra_reg[95:64];
        vy_reg <= ra_reg[63:32];
        vz_reg <= ra_reg[31:0];
        lo_ge_reg <= mass_reg >= window_reg;
        lo_reg <= mass_reg - window_reg;
        hi_reg <= {1'b0, mass_reg} + {1'b0, window_reg};
    end

    // stage 4: squares of magnitudes (33x33 unsigned after abs, 66-bit)
    function automatic logic [32:0] mg(input logic signed [32:0] v);
        mg = v[32] ? 33'(-v) : 33'(v);
    endfunction

    logic [65:0] qe_reg, qx_reg, qy_reg, qz_reg, qt_reg, qdx_reg, qdy_reg, qdz_reg;
    logic [47:0] ml_reg;
    logic [49:0] mh_reg;
    logic ge4_reg;
    logic [32:0] e4, x4, y4, z4;
    logic [31:0] t4v, x4v, y4v, z4v;
    logic rd4_reg, ch4_reg;

    always_ff @(posedge clk)
    begin
        qe_reg  <= mg(se_reg) * mg(se_reg);
        qx_reg  <= mg(sx_reg) * mg(sx_reg);
        qy_reg  <= mg(sy_reg) * mg(sy_reg);
        qz_reg  <= mg(sz_reg) * mg(sz_reg);
        qt_reg  <= mg(dt_reg) * mg(dt_reg);
        qdx_reg <= mg(dx_reg) * mg(dx_reg);
        qdy_reg <= mg(dy_reg) * mg(dy_reg);
        qdz_reg <= mg(dz_reg) * mg(dz_reg);
        ml_reg  <= lo_reg * lo_reg;
        mh_reg  <= hi_reg * hi_reg;
        ge4_reg <= lo_ge_reg;
        e4 <= se_reg; x4 <= sx_reg; y4 <= sy_reg; z4 <= sz_reg;
        t4v <= vt_reg; x4v <= vx_reg; y4v <= vy_reg; z4v <= vz_reg;
    end

    // stage 5: momentum and distance sums
    logic [67:0] pp_reg, dd_reg;
    logic [65:0] ee_reg;
    logic [47:0] ml5_reg;
    logic [49:0] mh5_reg;
    logic ge5_reg;
    logic [32:0] e5, x5, y5, z5;
    logic [31:0] t5v, x5v, y5v, z5v;
    logic rd5_reg, ch5_reg;

    always_ff @(posedge clk)
    begin
        pp_reg  <= 68'(qx_reg) + 68'(qy_reg) + 68'(qz_reg);
        dd_reg  <= 68'(qt_reg) + 68'(qdx_reg) + 68'(qdy_reg) + 68'(qdz_reg);
        ee_reg  <= qe_reg;
        ml5_reg <= ml_reg; mh5_reg <= mh_reg; ge5_reg <= ge4_reg;
        e5 <= e4; x5 <= x4; y5 <= y4; z5 <= z4;
        t5v <= t4v; x5v <= x4v; y5v <= y4v; z5v <= z4v;
    end

    // stage 6: bound sums and distance limit compare
    logic [68:0] blo_reg, bhi_reg, pp6_reg;
    logic [65:0] ee6_reg;
    logic dok_reg, ge6_reg;
    logic [32:0] e6, x6, y6, z6;
    logic [31:0] t6v, x6v, y6v, z6v;
    logic rd6_reg, ch6_reg;

    always_ff @(posedge clk)
    begin
        blo_reg <= 69'(pp_reg) + 69'(ml5_reg);
        bhi_reg <= 69'(pp_reg) + 69'(mh5_reg);
        pp6_reg <= 69'(pp_reg);
        ee6_reg <= ee_reg;
        dok_reg <= dd_reg < 68'(DistSqLimit);
        ge6_reg <= ge5_reg;
        e6 <= e5; x6 <= x5; y6 <= y5; z6 <= z5;
        t6v <= t5v; x6v <= x5v; y6v <= y5v; z6v <= z5v;
    end

    // stage 7: compares and result register
    logic lo_ok, hi_ok;
    assign lo_ok = ge6_reg ? (69'(ee6_reg) > blo_reg) : (69'(ee6_reg) >= pp6_reg);
    assign hi_ok = 69'(ee6_reg) < bhi_reg;

    always_ff @(posedge clk)
    begin
        p_e <= e6; p_x <= x6; p_y <= y6; p_z <= z6;
        v_t <= t6v; v_x <= x6v; v_y <= y6v; v_z <= z6v;
    end

    // valid and channel tags along the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            {rd1_reg, rd2_reg, rd3_reg, rd4_reg, rd5_reg, rd6_reg, pass} <= '0;
            {ch1_reg, ch2_reg, ch3_reg, ch4_reg, ch5_reg, ch6_reg, pass_chan} <= '0;
        end
        else
        begin
            rd1_reg <= cmd.rd;  ch1_reg <= cmd.chan;
            rd2_reg <= rd1_reg; ch2_reg <= ch1_reg;
            rd3_reg <= rd2_reg; ch3_reg <= ch2_reg;
            rd4_reg <= rd3_reg; ch4_reg <= ch3_reg;
            rd5_reg <= rd4_reg; ch5_reg <= ch4_reg;
            rd6_reg <= rd5_reg; ch6_reg <= ch5_reg;
            pass <= rd6_reg && lo_ok && hi_ok && dok_reg;
            pass_chan <= ch6_reg;
        end
    end
endmodule
`default_nettype wire

@@ design/rpf_ctrl.sv @@
// rpf_ctrl: state machine that walks the pair lists and emits results
// depends on rpf_pkg
`default_nettype none
module rpf_ctrl
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic end_of_event,
    output logic busy,
    output rpf_pkg::rpf_cmd_t cmd,
    input  rpf_pkg::rpf_stat_t stat,
    input  wire logic pass,
    output logic take,            // emit the pair held by the datapath
    output logic marker,          // emit the end of event marker
    output logic marker_ovf
);
    import rpf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PAIR  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_MARK  = 4'b1000
    } state_t;

    localparam int DrainCycles = 7;

    state_t state_reg, state_next;
    logic chan_reg, chan_next;
    logic [CntW-1:0] a_reg, a_next, b_reg, b_next;
    logic [2:0] drain_reg, drain_next;
    logic [CandW-1:0] ncand_reg, ncand_next;
    logic cdrop_reg, cdrop_next;
    logic [CntW-1:0] la, lb;
    logic ch2_reg, ch2_next;
    logic accept;

    assign accept = start && !busy;
    assign busy = state_reg != S_IDLE;
    assign la = chan_reg ? stat.cnt2 : stat.cnt0;
    assign lb = chan_reg ? stat.cnt3 : stat.cnt1;
    assign take = pass && ncand_reg < CandW'(MaxCandidates);

    // next state
    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        drain_next = drain_reg;
        // channel two enable sampled when pairing starts
        ch2_next   = (state_reg == S_IDLE) ? stat.ch2on : ch2_reg;
        ncand_next = take ? ncand_reg + CandW'(1) : ncand_reg;
        cdrop_next = cdrop_reg | (pass && !take);
        cmd.load   = accept;
        cmd.rd     = 1'b0;
        cmd.chan   = chan_reg;
        cmd.a_idx  = a_reg[IdxW-1:0];
        cmd.b_idx  = b_reg[IdxW-1:0];
        cmd.clear  = 1'b0;
        marker     = 1'b0;
        marker_ovf = stat.drop | cdrop_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && end_of_event)
                begin
                    state_next = S_PAIR;
                    chan_next = 1'b0;
                    a_next = '0;
                    b_next = '0;
                    ncand_next = '0;
                    cdrop_next = 1'b0;
                end
            end
            S_PAIR:
            begin
                if (a_reg >= la || lb == '0)
                begin
                    if (!chan_reg && ch2_reg)
                    begin
                        chan_next = 1'b1;
                        a_next = '0;
                        b_next = '0;
                    end
                    else
                    begin
                        state_next = S_DRAIN;
                        drain_next = '0;
                    end
                end
                else
                begin
                    cmd.rd = 1'b1;
                    if (b_reg + CntW'(1) >= lb)
                    begin
                        b_next = '0;
                        a_next = a_reg + CntW'(1);
                    end
                    else
                        b_next = b_reg + CntW'(1);
                end
            end
            S_DRAIN:
            begin
                drain_next = drain_reg + 3'd1;
                if (drain_reg == 3'(DrainCycles - 1))
                    state_next = S_MARK;
            end
            S_MARK:
            begin
                marker = 1'b1;
                cmd.clear = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            chan_reg  <= 1'b0;
            a_reg     <= '0;
            b_reg     <= '0;
            drain_reg <= '0;
            ncand_reg <= '0;
            cdrop_reg <= 1'b0;
            ch2_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            drain_reg <= drain_next;
            ncand_reg <= ncand_next;
            cdrop_reg <= cdrop_next;
            ch2_reg   <= ch2_next;
        end
    end
endmodule
`default_nettype wire

@@ design/resonance_pair_finder_top.sv @@
// resonance_pair_finder_top: top level joining controller and datapath
// depends on rpf_pkg, rpf_ctrl, rpf_datapath
//
// usage: one particle beat is taken at a clock edge with start high and busy
// low. matching particles are written to the store in that cycle, so
// particles that do not end the event can be taken back to back. a beat with
// end_of_event set starts pairing: each listed first-by-second pair goes
// through a seven-stage pipeline (list read, store read, sums, squares,
// adds, bound sums, compares), a new pair entering before the last is
// through; busy stays high until the end of event marker has been sent.
// found pairs, up to 63 per event, appear on the result ports with done
// high for one cycle each, and the end of event marker follows with
// last_result high. the receiver cannot stall; every strobed result is
// taken as it comes. configuration is to be written through cfg_we /
// cfg_index / cfg_data while busy is low; the block itself does not
// enforce this. reset clears counts and loads the default registers;
// stores need no clearing pass as only entries of the running event are read.
`default_nettype none
module resonance_pair_finder_top
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic start,
    output logic busy,
    input  wire logic [23:0] species_code,
    input  wire logic [31:0] energy,
    input  wire logic [31:0] mom_x,
    input  wire logic [31:0] mom_y,
    input  wire logic [31:0] mom_z,
    input  wire logic [31:0] pos_t,
    input  wire logic [31:0] pos_x,
    input  wire logic [31:0] pos_y,
    input  wire logic [31:0] pos_z,
    input  wire logic end_of_event,
    output logic done,
    output logic is_candidate,
    output logic channel,
    output logic [32:0] sum_energy,
    output logic [32:0] sum_mom_x,
    output logic [32:0] sum_mom_y,
    output logic [32:0] sum_mom_z,
    output logic [31:0] vertex_t,
    output logic [31:0] vertex_x,
    output logic [31:0] vertex_y,
    output logic [31:0] vertex_z,
    output logic overflow,
    output logic last_result
);
    import rpf_pkg::*;

    rpf_cmd_t cmd;
    rpf_stat_t stat;
    logic pass, pass_chan, take, marker, marker_ovf;
    logic [32:0] p_e, p_x, p_y, p_z;
    logic [31:0] v_t, v_x, v_y, v_z;

    rpf_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .start(start), .end_of_event(end_of_event),
        .busy(busy), .cmd(cmd), .stat(stat), .pass(pass), .take(take),
        .marker(marker), .marker_ovf(marker_ovf)
    );

    rpf_datapath u_dp
    (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .species_code(species_code), .energy(energy),
        .mom_x(mom_x), .mom_y(mom_y), .mom_z(mom_z), .pos_t(pos_t),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .cmd(cmd), .stat(stat),
        .pass(pass), .pass_chan(pass_chan), .p_e(p_e), .p_x(p_x), .p_y(p_y),
        .p_z(p_z), .v_t(v_t), .v_x(v_x), .v_y(v_y), .v_z(v_z)
    );

    // output beat: pair or marker
    always_comb
    begin
        done         = take | marker;
        is_candidate = take;
        channel      = take & pass_chan;
        sum_energy   = take ? p_e : '0;
        sum_mom_x    = take ? p_x : '0;
        sum_mom_y    = take ? p_y : '0;
        sum_mom_z    = take ? p_z : '0;
        vertex_t     = take ? v_t : '0;
        vertex_x     = take ? v_x : '0;
        vertex_y     = take ? v_y : '0;
        vertex_z     = take ? v_z : '0;
        overflow     = marker & marker_ovf;
        last_result  = marker;
    end
endmodule
`default_nettype wire
